### sv/multilevel_priority_fifo_macros.svh
// Assertion macros shared by the checker of the multilevel priority FIFO.
`ifndef MULTILEVEL_PRIORITY_FIFO_MACROS_SVH
`define MULTILEVEL_PRIORITY_FIFO_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/mpf_pkg.sv
// Shared types and constants of the multilevel priority FIFO.
`timescale 1ns / 1ps
`default_nettype none

package mpf_pkg;

    localparam int SEV_W    = 3;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = SEV_W + ID_W + ID_W + TIME_W;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 80;
    localparam int M_PAD_W  = M_DATA_W - ENTRY_W - COUNT_W;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STAT_INSERTED = 2'd0;
    localparam status_t STAT_REMOVED  = 2'd1;
    localparam status_t STAT_EMPTY    = 2'd2;
    localparam status_t STAT_FULL     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_ALLOC,
        ST_INS_LINK,
        ST_REM,
        ST_REPLY
    } state_t;

endpackage

`default_nettype wire

### sv/mpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/multilevel_priority_fifo.sv
// Top level of the multilevel priority FIFO: linked list in an entry pool with per-level tails.
`timescale 1ns / 1ps
`default_nettype none

// A priority queue of up to CAPACITY reports in LEVELS severity levels. Each input
// transaction is an insert or a remove and yields exactly one output transaction that
// carries a status and the entry count after the operation. Entries live in one linked
// list held in block RAMs with registered reads; a tail register per level finds the
// insertion point. A transaction occupies the block until it completes: the accept
// cycle issues the RAM reads, a removal or a plain insert completes in the next state,
// and an insert behind an existing tail passes a further state for the second write to
// the link memory, which has a single write port. The free-entry ring needs no
// clearing pass after reset: a fill count marks which ring slots were rewritten, and
// the block accepts transactions from the first cycle after reset. A finished result
// waits in the output register, and completion stalls while that register is full.
module multilevel_priority_fifo #(
    parameter int LEVELS   = 8,
    parameter int CAPACITY = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // severity[2:0], patient_id[18:3], exam_id[34:19], arrival_time[66:35], zero fill
    input  logic [mpf_pkg::S_DATA_W-1:0]   s_tdata,
    // mode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_severity[2:0], out_patient_id[18:3], out_exam_id[34:19], out_time[66:35],
    // entry_count[75:67], zero fill
    output logic [mpf_pkg::M_DATA_W-1:0]   m_tdata,
    // status
    output logic [mpf_pkg::STATUS_W-1:0]   m_tuser
);

    import mpf_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = $clog2(LEVELS);
    localparam logic [AW-1:0] LAST_POS  = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      free_head_reg, free_head_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [LEVELS-1:0]  tail_valid_reg, tail_valid_next;
    logic [AW-1:0]      tail_idx_reg [LEVELS];
    logic [AW-1:0]      tail_idx_next [LEVELS];
    logic               m_tvalid_reg, m_tvalid_next;

    logic               mode_reg, mode_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [LW-1:0]      lvl_reg, lvl_next;
    logic [AW-1:0]      laddr_reg, laddr_next;
    logic               found_reg, found_next;
    logic [AW-1:0]      e_reg, e_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    status_t            m_tuser_reg, m_tuser_next;

    logic               s_fire;
    logic               out_free;
    logic               alloc_go;
    logic [SEV_W-1:0]   in_sev;
    logic [SEV_W-1:0]   in_sev_sat;
    logic [LW-1:0]      in_lvl;
    logic               srch_found;
    logic [AW-1:0]      srch_idx;
    logic [AW-1:0]      alloc_idx;
    logic [LW-1:0]      rem_lvl;

    logic               pay_we;
    logic [ENTRY_W-1:0] pay_rdata;
    logic               link_we;
    logic [AW-1:0]      link_waddr;
    logic [AW-1:0]      link_wdata;
    logic [AW-1:0]      link_raddr;
    logic [AW-1:0]      link_rdata;
    logic               free_we;
    logic [AW-1:0]      free_rdata;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign alloc_go = (state_reg == ST_INS_ALLOC) && (found_reg || out_free);

    assign in_sev     = s_tdata[SEV_W-1:0];
    assign in_sev_sat = (32'(in_sev) >= LEVELS) ? SEV_W'(LEVELS - 1) : in_sev;
    assign in_lvl     = LW'(in_sev_sat);

    assign alloc_idx = (CW'(free_head_reg) < fill_reg) ? free_rdata : free_head_reg;
    assign rem_lvl   = LW'(pay_rdata[SEV_W-1:0]);

    always_comb
    begin
        srch_found = 1'b0;
        srch_idx   = head_reg;
        for (int lv = LEVELS - 1; lv >= 0; lv--)
        begin
            if (tail_valid_reg[lv] && (LW'(lv) >= in_lvl))
            begin
                srch_found = 1'b1;
                srch_idx   = tail_idx_reg[lv];
            end
        end
    end

    mpf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (alloc_idx),
        .wdata (entry_reg),
        .raddr (head_reg),
        .rdata (pay_rdata)
    );

    mpf_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    mpf_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (wr_ptr_reg),
        .wdata (head_reg),
        .raddr (free_head_reg),
        .rdata (free_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_tuser == MODE_INSERT)
                    begin
                        state_next = (count_reg == CAP_COUNT) ? ST_REPLY : ST_INS_ALLOC;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_REPLY : ST_REM;
                    end
                end
            end
            ST_INS_ALLOC:
            begin
                if (found_reg)
                begin
                    state_next = ST_INS_LINK;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_INS_LINK, ST_REM, ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE);
        pay_we     = 1'b0;
        link_we    = 1'b0;
        link_waddr = alloc_idx;
        link_wdata = head_reg;
        link_raddr = laddr_reg;
        free_we    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                link_raddr = (s_tuser == MODE_INSERT) ? srch_idx : head_reg;
            end
            ST_INS_ALLOC:
            begin
                pay_we     = alloc_go;
                link_we    = alloc_go;
                link_wdata = found_reg ? link_rdata : head_reg;
            end
            ST_INS_LINK:
            begin
                link_we    = out_free;
                link_waddr = laddr_reg;
                link_wdata = e_reg;
            end
            ST_REM:
            begin
                free_we = out_free;
            end
            ST_REPLY:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        fill_next       = fill_reg;
        free_head_next  = free_head_reg;
        wr_ptr_next     = wr_ptr_reg;
        head_next       = head_reg;
        tail_valid_next = tail_valid_reg;
        tail_idx_next   = tail_idx_reg;
        mode_next       = mode_reg;
        entry_next      = entry_reg;
        lvl_next        = lvl_reg;
        laddr_next      = laddr_reg;
        found_next      = found_reg;
        e_next          = e_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    mode_next  = s_tuser;
                    entry_next = {s_tdata[ENTRY_W-1:SEV_W], in_sev_sat};
                    lvl_next   = in_lvl;
                    if (s_tuser == MODE_INSERT)
                    begin
                        laddr_next = srch_idx;
                        found_next = srch_found;
                    end
                    else
                    begin
                        laddr_next = head_reg;
                        found_next = 1'b0;
                    end
                end
            end
            ST_INS_ALLOC:
            begin
                if (alloc_go)
                begin
                    free_head_next = (free_head_reg == LAST_POS) ? '0 : free_head_reg + 1'b1;
                    e_next         = alloc_idx;
                    if (!found_reg)
                    begin
                        head_next              = alloc_idx;
                        tail_valid_next[lvl_reg] = 1'b1;
                        tail_idx_next[lvl_reg]   = alloc_idx;
                        count_next             = count_reg + 1'b1;
                        m_tvalid_next          = 1'b1;
                        m_tuser_next           = STAT_INSERTED;
                        m_tdata_next           = {{M_PAD_W{1'b0}},
                                                  COUNT_W'(count_reg + 1'b1),
                                                  {ENTRY_W{1'b0}}};
                    end
                end
            end
            ST_INS_LINK:
            begin
                if (out_free)
                begin
                    tail_valid_next[lvl_reg] = 1'b1;
                    tail_idx_next[lvl_reg]   = e_reg;
                    count_next             = count_reg + 1'b1;
                    m_tvalid_next          = 1'b1;
                    m_tuser_next           = STAT_INSERTED;
                    m_tdata_next           = {{M_PAD_W{1'b0}},
                                              COUNT_W'(count_reg + 1'b1),
                                              {ENTRY_W{1'b0}}};
                end
            end
            ST_REM:
            begin
                if (out_free)
                begin
                    head_next   = link_rdata;
                    wr_ptr_next = (wr_ptr_reg == LAST_POS) ? '0 : wr_ptr_reg + 1'b1;
                    if (fill_reg != CAP_COUNT)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (tail_idx_reg[rem_lvl] == head_reg)
                    begin
                        tail_valid_next[rem_lvl] = 1'b0;
                    end
                    count_next    = count_reg - 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = STAT_REMOVED;
                    m_tdata_next  = {{M_PAD_W{1'b0}},
                                     COUNT_W'(count_reg - 1'b1),
                                     pay_rdata};
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = (mode_reg == MODE_INSERT) ? STAT_FULL : STAT_EMPTY;
                    m_tdata_next  = {{M_PAD_W{1'b0}},
                                     COUNT_W'(count_reg),
                                     {ENTRY_W{1'b0}}};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            fill_reg       <= '0;
            free_head_reg  <= '0;
            wr_ptr_reg     <= '0;
            head_reg       <= '0;
            tail_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            fill_reg       <= fill_next;
            free_head_reg  <= free_head_next;
            wr_ptr_reg     <= wr_ptr_next;
            head_reg       <= head_next;
            tail_valid_reg <= tail_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_idx_reg <= tail_idx_next;
        mode_reg     <= mode_next;
        entry_reg    <= entry_next;
        lvl_reg      <= lvl_next;
        laddr_reg    <= laddr_next;
        found_reg    <= found_next;
        e_reg        <= e_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

### sv/mpf_checker.sv
// Port-level checker of the multilevel priority FIFO and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

`include "multilevel_priority_fifo_macros.svh"

module mpf_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [mpf_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic [mpf_pkg::STATUS_W-1:0] m_tuser
);

    import mpf_pkg::*;

    // A stalled output transaction keeps its contents.
    `MPF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Each accepted transaction occupies the block, so s_tready is low while the block holds it.
    `MPF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // Only a removal carries entry fields.
    `MPF_ASSERT_SAME(a_fields_zero, clk, rst_n, m_tvalid && (m_tuser != STAT_REMOVED), m_tdata[ENTRY_W-1:0] == '0)

    // A remove that finds the queue empty reports a count of zero.
    `MPF_ASSERT_SAME(a_empty_count, clk, rst_n, m_tvalid && (m_tuser == STAT_EMPTY), m_tdata[ENTRY_W+COUNT_W-1:ENTRY_W] == '0)

endmodule

bind multilevel_priority_fifo mpf_checker u_mpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
